FILE: rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int KEY_BITS        = 32;
  localparam int DATA_BITS       = 32;
  localparam int CAP_BITS        = 5;
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int CAP_RESET       = 16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } op_e;

  typedef struct packed {
    op_e                          op;
    logic signed [KEY_BITS-1:0]   key;
    logic signed [DATA_BITS-1:0]  value;
  } req_t;

  typedef struct packed {
    logic                         found;
    logic signed [DATA_BITS-1:0]  read_value;
    logic                         evicted;
    logic signed [KEY_BITS-1:0]   evicted_key;
  } rsp_t;

endpackage

FILE: rtl/lkv_lookup.sv
// ----------------------------------------------------------------------------
// lkv_lookup
// Parallel tag compare and slot selection: the matching entry, the first
// free entry and the least recently used entry.
// ----------------------------------------------------------------------------
module lkv_lookup #(
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF,
  localparam int IdxW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int RankW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int CntW  = $clog2(MAX_ENTRIES + 1)
) (
  input  logic [MAX_ENTRIES-1:0]            valid_i,
  input  logic [lkv_pkg::KEY_BITS-1:0]      key_i [MAX_ENTRIES],
  input  logic [RankW-1:0]                  rank_i [MAX_ENTRIES],
  input  logic [CntW-1:0]                   count_i,
  input  logic [lkv_pkg::KEY_BITS-1:0]      lookup_key_i,
  output logic [MAX_ENTRIES-1:0]            hit_oh_o,
  output logic                              hit_o,
  output logic [IdxW-1:0]                   hit_idx_o,
  output logic                              free_o,
  output logic [IdxW-1:0]                   free_idx_o,
  output logic                              victim_o,
  output logic [IdxW-1:0]                   victim_idx_o
);

  logic [CntW-1:0] oldest_rank;

  assign oldest_rank = count_i - CntW'(1);

  always_comb begin
    hit_oh_o     = '0;
    hit_o        = 1'b0;
    hit_idx_o    = '0;
    free_o       = 1'b0;
    free_idx_o   = '0;
    victim_o     = 1'b0;
    victim_idx_o = '0;
    // Scanning from the top down leaves the lowest matching index selected.
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      hit_oh_o[i] = valid_i[i] && (key_i[i] == lookup_key_i);
      if (hit_oh_o[i]) begin
        hit_o     = 1'b1;
        hit_idx_o = IdxW'(i);
      end
      if (!valid_i[i]) begin
        free_o     = 1'b1;
        free_idx_o = IdxW'(i);
      end
      // Valid ranks always form 0 .. count-1, so the oldest has rank count-1.
      if (valid_i[i] && (CntW'(rank_i[i]) == oldest_rank)) begin
        victim_o     = 1'b1;
        victim_idx_o = IdxW'(i);
      end
    end
  end

endmodule

FILE: rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement,
// recency kept as one rank per entry (0 is the most recent).
//
//   Channel   Direction  Handshake                  Word
//   req       in         req_valid_i / req_ready_o  op, key, value
//   rsp       out        rsp_valid_o / rsp_ready_i  found, read_value, evicted,
//                                                   evicted_key
//   cfg       in         cfg_we_i                   capacity
//
// One access per clock while the response side is not stalled: an input register,
// one pass of tag compare and rank update, and a response register. A response
// word is registered from the input register once the response register is
// empty or being taken. Reset and a capacity write empty the store at once by
// clearing the valid bits; there is no clearing pass. A stalled response holds
// the input register, and the request side keeps taking words as long as that register drains.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  lkv_pkg::req_t                 req_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output lkv_pkg::rsp_t                 rsp_o,
  input  logic                          cfg_we_i,
  input  logic [lkv_pkg::CAP_BITS-1:0]  cfg_wdata_i
);

  localparam int IdxW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RankW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int CapResetEff =
    (lkv_pkg::CAP_RESET > MAX_ENTRIES) ? MAX_ENTRIES : lkv_pkg::CAP_RESET;

  // Pipeline registers
  lkv_pkg::req_t  in_q;
  logic           in_valid_q, in_valid_d;
  lkv_pkg::rsp_t  rsp_q, rsp_d;
  logic           rsp_valid_q, rsp_valid_d;

  // Store
  logic [lkv_pkg::KEY_BITS-1:0]  key_q   [MAX_ENTRIES];
  logic [lkv_pkg::DATA_BITS-1:0] value_q [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]        valid_q, valid_d;
  logic [RankW-1:0]              rank_q  [MAX_ENTRIES];
  logic [RankW-1:0]              rank_d  [MAX_ENTRIES];
  logic [CntW-1:0]               count_q, count_d;
  logic [CntW-1:0]               cap_q, cap_d;

  // Lookup results
  logic [MAX_ENTRIES-1:0] hit_oh;
  logic                   hit, free_any, victim_any;
  logic [IdxW-1:0]        hit_idx, free_idx, victim_idx, slot;

  logic            fire, accept, is_set, do_fill, do_evict, touch;
  logic [CntW:0]   limit;
  logic [CntW-1:0] cap_eff;

  lkv_lookup #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_lookup (
    .valid_i      (valid_q),
    .key_i        (key_q),
    .rank_i       (rank_q),
    .count_i      (count_q),
    .lookup_key_i (in_q.key),
    .hit_oh_o     (hit_oh),
    .hit_o        (hit),
    .hit_idx_o    (hit_idx),
    .free_o       (free_any),
    .free_idx_o   (free_idx),
    .victim_o     (victim_any),
    .victim_idx_o (victim_idx)
  );

  // Handshake
  assign fire        = in_valid_q && (!rsp_valid_q || rsp_ready_i);
  assign req_ready_o = !in_valid_q || fire;
  assign accept      = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  assign in_valid_d  = accept || (in_valid_q && !fire);
  assign rsp_valid_d = fire || (rsp_valid_q && !rsp_ready_i);

  // Access decode
  assign is_set   = (in_q.op == lkv_pkg::OP_SET);
  assign do_fill  = !hit && is_set && (count_q < cap_q) && free_any;
  assign do_evict = !hit && is_set && !do_fill;
  assign touch    = hit || is_set;
  assign slot     = hit ? hit_idx : (do_fill ? free_idx : victim_idx);

  // Entries younger than the promoted one age by one place.
  assign limit = do_fill ? ({1'b0, count_q} + (CntW + 1)'(1))
                         : (CntW + 1)'(rank_q[slot]);

  always_comb begin
    rsp_d.found       = hit;
    rsp_d.evicted     = do_evict;
    rsp_d.evicted_key = do_evict ? key_q[victim_idx] : '0;
    if (is_set) begin
      rsp_d.read_value = in_q.value;
    end else if (hit) begin
      rsp_d.read_value = value_q[hit_idx];
    end else begin
      rsp_d.read_value = '1;
    end
  end

  // Capacity as used: zero acts as one, large values saturate.
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cap_eff = CntW'(1);
    end else if (int'(cfg_wdata_i) > MAX_ENTRIES) begin
      cap_eff = CntW'(MAX_ENTRIES);
    end else begin
      cap_eff = CntW'(cfg_wdata_i);
    end
  end

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    count_d = count_q;
    cap_d   = cap_q;
    priority if (cfg_we_i) begin
      cap_d   = cap_eff;
      valid_d = '0;
      count_d = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_d[i] = '0;
      end
    end else if (fire && touch) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (IdxW'(i) == slot) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && ((CntW + 1)'(rank_q[i]) < limit)) begin
          rank_d[i] = rank_q[i] + RankW'(1);
        end
      end
      if (do_fill) begin
        valid_d[slot] = 1'b1;
        count_d       = count_q + CntW'(1);
      end
    end else begin
      // No write and no access that touches the store: everything holds.
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      valid_q     <= '0;
      count_q     <= '0;
      cap_q       <= CntW'(CapResetEff);
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      in_valid_q  <= in_valid_d;
      rsp_valid_q <= rsp_valid_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      cap_q       <= cap_d;
      rank_q      <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= req_i;
    end
    if (fire) begin
      rsp_q <= rsp_d;
      if (is_set) begin
        value_q[slot] <= in_q.value;
        if (!hit) begin
          key_q[slot] <= in_q.key;
        end
      end
    end
  end

  // Keys in the store are unique, so at most one entry matches.
  a_hit_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |-> $onehot0(hit_oh))
    else $error("more than one entry matches the key");

  a_count_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("entry count disagrees with valid bits");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("entry count above capacity");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && do_evict) |-> (victim_any && (count_q == cap_q)))
    else $error("eviction without a full store");

endmodule
